### sv/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/srsg_pkg.sv
package srsg_pkg;

  localparam int RATE_W    = 24;
  localparam int DIFF_W    = RATE_W + 1;
  localparam int TIMER_W   = 17;
  localparam int RCHG_W    = 23;
  localparam int INTV_W    = 16;
  localparam int CFG_W     = 23;
  localparam int CFG_IDX_W = 2;
  localparam int POS_OUT_W = 32;

  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE_CHANGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_INTERVAL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVER_ENABLE   = 2'd2;

  // command codes
  localparam logic [1:0] FUNC_TICK     = 2'd0;
  localparam logic [1:0] FUNC_SET_RATE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR    = 2'd2;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [RATE_W-1:0] rate_command;
  } cmd_t;

  typedef struct packed {
    logic                        step_pulse;
    logic                        step_forward;
    logic signed [POS_OUT_W-1:0] position;
    logic signed [RATE_W-1:0]    present_rate;
    logic                        enable_n;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CLAMP,
    S_ADD,
    S_DIV_LOAD,
    S_DIVIDE,
    S_PERIOD,
    S_FINISH
  } state_t;

endpackage

### sv/stepper_ramp_step_generator.sv
// a tick that runs a ramp update passes EXEC, CLAMP, ADD, DIV_LOAD, DIVIDE, PERIOD and FINISH,
// skipping DIVIDE and PERIOD when the updated rate is zero; any other item goes EXEC then FINISH
// the restoring period divider retires one quotient bit per cycle in DIVIDE; a new item is
// taken only back in IDLE, after the previous one has been loaded into the output register
// a result ready while the previous one still waits holds the sequencer in FINISH
// reset: synchronous active-high rst clears rates, timers and position, loads register defaults
module stepper_ramp_step_generator
  import srsg_pkg::*;
#(
  parameter int RATE_FRAC_BITS   = 8,
  parameter int TICKS_PER_SECOND = 1000000,
  parameter int POSITION_BITS    = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  // command channel
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  cmd_t                 cmd,
  // result channel
  output logic                 res_valid,
  input  logic                 res_ready,
  output res_t                 res,
  // configuration write port
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // dividend of the period divide: ticks per second scaled to the rate fraction
  localparam int DIV_W = $clog2(TICKS_PER_SECOND + 1) + RATE_FRAC_BITS;
  localparam int QUO_W = (DIV_W > TIMER_W) ? DIV_W : TIMER_W;
  localparam int CNT_W = $clog2(QUO_W);
  localparam logic [QUO_W-1:0] DIVIDEND = QUO_W'(TICKS_PER_SECOND) << RATE_FRAC_BITS;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);
  // lowest rate that issues steps: 8 steps per second
  localparam logic signed [RATE_W-1:0] MIN_RATE = RATE_W'(8 << RATE_FRAC_BITS);

  state_t state, state_next;

  // configuration registers
  logic [RCHG_W-1:0] max_rate_change;
  logic [INTV_W-1:0] ramp_interval;
  logic              driver_enable;

  // motion state
  logic signed [RATE_W-1:0] requested_rate;
  logic signed [RATE_W-1:0] current_rate;
  logic [INTV_W-1:0]        ramp_timer;
  logic [TIMER_W-1:0]       step_timer;
  logic [TIMER_W-1:0]       step_period;
  logic [POSITION_BITS-1:0] step_count;
  logic                     last_direction;

  // item held while it is worked on
  cmd_t cmd_q;

  // ramp and divider working registers
  logic signed [DIFF_W-1:0] diff;
  logic [RATE_W-1:0]        divisor;
  logic [RATE_W-1:0]        rem;
  logic [QUO_W-1:0]         quo;
  logic [CNT_W-1:0]         cnt;

  // combinational helpers
  logic [INTV_W-1:0]        interval_eff;
  logic [INTV_W:0]          ramp_sum;
  logic                     ramp_fire;
  logic signed [DIFF_W-1:0] lim;
  logic [RATE_W:0]          rem_sh;
  logic                     rem_ge;
  logic                     rate_ok;
  logic                     pulse;
  logic                     fwd;
  logic [POSITION_BITS-1:0] count_next;
  logic                     can_load;

  // zero interval behaves as one: update on every tick
  assign interval_eff = (ramp_interval == '0) ? INTV_W'(1) : ramp_interval;
  assign ramp_sum     = {1'b0, ramp_timer} + (INTV_W+1)'(1);
  assign ramp_fire    = ramp_sum >= {1'b0, interval_eff};
  assign lim          = $signed({2'b00, max_rate_change});

  // one restoring divide step: shift in the next dividend bit, trial subtract
  assign rem_sh = {rem, DIVIDEND[cnt]};
  assign rem_ge = rem_sh >= {1'b0, divisor};

  // step test on the post-ramp rate and period, no negation needed
  always_comb begin
    rate_ok    = (current_rate >= MIN_RATE) || (current_rate <= -MIN_RATE);
    pulse      = (cmd_q.func == FUNC_TICK) && rate_ok && (step_timer >= step_period);
    fwd        = current_rate > 0;
    count_next = fwd ? step_count + POSITION_BITS'(1) : step_count - POSITION_BITS'(1);
  end

  // output slot free, or freed by a transfer this cycle
  assign can_load = !res_valid || res_ready;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_q.func == FUNC_TICK && ramp_fire) state_next = S_CLAMP;
        else state_next = S_FINISH;
      end
      S_CLAMP: state_next = S_ADD;
      S_ADD: state_next = S_DIV_LOAD;
      S_DIV_LOAD: begin
        // zero rate skips the divide
        if (current_rate == '0) state_next = S_FINISH;
        else state_next = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (cnt == '0) state_next = S_PERIOD;
      end
      S_PERIOD: state_next = S_FINISH;
      S_FINISH: begin
        if (can_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_rate_change <= RCHG_W'(256);
      ramp_interval   <= INTV_W'(500);
      driver_enable   <= 1'b0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_MAX_RATE_CHANGE: max_rate_change <= cfg_data[RCHG_W-1:0];
        REG_RAMP_INTERVAL:   ramp_interval   <= cfg_data[INTV_W-1:0];
        REG_DRIVER_ENABLE:   driver_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // motion state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      requested_rate <= '0;
      current_rate   <= '0;
      ramp_timer     <= '0;
      step_timer     <= '0;
      step_period    <= TIMER_MAX;
      step_count     <= '0;
      last_direction <= 1'b0;
    end else begin
      case (state)
        S_EXEC: begin
          case (cmd_q.func)
            FUNC_TICK: begin
              // step timer saturates
              if (step_timer != TIMER_MAX) step_timer <= step_timer + TIMER_W'(1);
              if (ramp_fire) ramp_timer <= '0;
              else ramp_timer <= ramp_sum[INTV_W-1:0];
            end
            FUNC_SET_RATE: requested_rate <= cmd_q.rate_command;
            FUNC_CLEAR: begin
              requested_rate <= '0;
              current_rate   <= '0;
              ramp_timer     <= '0;
              step_timer     <= '0;
              step_period    <= TIMER_MAX;
            end
            default: ;
          endcase
        end
        S_ADD: current_rate <= RATE_W'(DIFF_W'(current_rate) + diff);
        S_DIV_LOAD: begin
          if (current_rate == '0) step_period <= TIMER_MAX;
        end
        S_PERIOD: begin
          // quotient above the timer range saturates
          step_period <= (quo > QUO_W'(TIMER_MAX)) ? TIMER_MAX : quo[TIMER_W-1:0];
        end
        S_FINISH: begin
          if (can_load && pulse) begin
            last_direction <= fwd;
            step_count     <= count_next;
            step_timer     <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath working registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (cmd_valid) cmd_q <= cmd;
      end
      S_EXEC: diff <= DIFF_W'(requested_rate) - DIFF_W'(current_rate);
      S_CLAMP: begin
        // limit the change to the configured step
        if (diff > lim) diff <= lim;
        else if (diff < -lim) diff <= -lim;
      end
      S_DIV_LOAD: begin
        // magnitude of the most negative rate still fits unsigned
        divisor <= current_rate[RATE_W-1] ? RATE_W'(-current_rate) : RATE_W'(current_rate);
        rem     <= '0;
        quo     <= '0;
        cnt     <= CNT_LAST;
      end
      S_DIVIDE: begin
        rem <= rem_ge ? RATE_W'(rem_sh - {1'b0, divisor}) : rem_sh[RATE_W-1:0];
        quo <= {quo[QUO_W-2:0], rem_ge};
        cnt <= cnt - CNT_W'(1);
      end
      default: ;
    endcase
  end

  // output register: holds a result until its transfer while the next item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_FINISH && can_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && can_load) begin
      res.step_pulse   <= pulse;
      res.step_forward <= pulse ? fwd : last_direction;
      res.position     <= POS_OUT_W'(pulse ? count_next : step_count);
      res.present_rate <= current_rate;
      res.enable_n     <= ~driver_enable;
    end
  end

endmodule

### sv/srsg_checker.sv
`include "assert_macros.svh"

module srsg_checker
  import srsg_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input logic res_valid,
  input logic res_ready,
  input res_t res
);

  // the sequencer leaves idle on every transfer
  `ASSERT_NEXT(a_busy_after_cmd, clk, rst, cmd_valid && cmd_ready, !cmd_ready, "ready right after a command transfer")

  // a step never comes from a zero rate
  `ASSERT_IMPL(a_step_needs_rate, clk, rst, res_valid && res.step_pulse, res.present_rate != 0, "step issued at zero rate")

  // direction of a step follows the sign of the rate
  `ASSERT_IMPL(a_step_direction, clk, rst, res_valid && res.step_pulse, res.step_forward == (res.present_rate > 0), "step direction does not match rate sign")

  // a stalled result holds
  `ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res), "stalled result changed")

endmodule

bind stepper_ramp_step_generator srsg_checker u_srsg_checker (.*);
